// ===== rtl/erm_pkg.sv =====
package erm_pkg;

	localparam int TRIG_ITERATIONS = 16;
	localparam int ATAN_ENTRIES    = 24;
	localparam int N_ITER = (TRIG_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_ITERATIONS;
	localparam int LANE_STAGES  = N_ITER + 1;     // fold + iterations
	localparam int MERGE_STAGES = 4;
	localparam int PIPE_DEPTH   = LANE_STAGES + MERGE_STAGES;

	typedef logic signed [33:0] cq_t;   // Q30 CORDIC word
	typedef logic signed [23:0] tv_t;   // Q20 sine / cosine
	typedef logic signed [47:0] pr_t;   // Q40 product
	typedef logic signed [51:0] pp_t;   // partial Q60 product
	typedef logic signed [15:0] ent_t;  // Q1.14 entry

	localparam cq_t CORDIC_GAIN = 34'sd652032874;
	localparam cq_t PI_Q30      = 34'sd3373259426;
	localparam cq_t HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [65:0] HALF_Q46 = 66'sd1 <<< 45;
	localparam logic signed [65:0] ENT_MAX  = 66'sd16384;

	function automatic cq_t atan_q30(input int idx);
		cq_t r;
		case (idx)
			0:  r = 34'h03243F6A8;
			1:  r = 34'h01DAC6705;
			2:  r = 34'h00FADBAFC;
			3:  r = 34'h007F56EA6;
			4:  r = 34'h003FEAB76;
			5:  r = 34'h001FFD55B;
			6:  r = 34'h000FFFAAA;
			7:  r = 34'h0007FFF55;
			8:  r = 34'h0003FFFEA;
			9:  r = 34'h0001FFFFD;
			10: r = 34'h0000FFFFF;
			11: r = 34'h00007FFFF;
			12: r = 34'h00003FFFF;
			13: r = 34'h00001FFFF;
			14: r = 34'h00000FFFF;
			15: r = 34'h000007FFF;
			16: r = 34'h000003FFF;
			17: r = 34'h000001FFF;
			18: r = 34'h000000FFF;
			19: r = 34'h0000007FF;
			20: r = 34'h0000003FF;
			21: r = 34'h0000001FF;
			22: r = 34'h0000000FF;
			23: r = 34'h00000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q60 sum to clamped Q1.14, round half up
	function automatic ent_t round_clamp(input logic signed [65:0] q60);
		logic signed [65:0] v;
		v = (q60 + HALF_Q46) >>> 46;
		if (v > ENT_MAX)
			v = ENT_MAX;
		else if (v < -ENT_MAX)
			v = -ENT_MAX;
		return v[15:0];
	endfunction

endpackage

// ===== rtl/erm_if.sv =====
interface erm_in_if;
	import erm_pkg::*;
	logic valid;
	logic ready;
	logic signed [15:0] angle_x;
	logic signed [15:0] angle_y;
	logic signed [15:0] angle_z;
	modport source (output valid, angle_x, angle_y, angle_z, input ready);
	modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface erm_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] m00;
	logic signed [15:0] m01;
	logic signed [15:0] m02;
	logic signed [15:0] m10;
	logic signed [15:0] m11;
	logic signed [15:0] m12;
	logic signed [15:0] m20;
	logic signed [15:0] m21;
	logic signed [15:0] m22;
	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
	modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

// ===== rtl/erm_cordic.sv =====
module erm_cordic
	import erm_pkg::*;
(
	input  logic                   clk,
	input  logic [LANE_STAGES-1:0] adv,
	input  logic signed [15:0]     angle,
	output cq_t                    x,
	output cq_t                    y,
	output logic                   neg_cos
);

	cq_t  x_q [0:N_ITER];
	cq_t  y_q [0:N_ITER];
	cq_t  z_q [0:N_ITER];
	logic n_q [0:N_ITER];
	cq_t  z_in;

	assign z_in = cq_t'($signed({angle, 17'b0}));

	// fold into [-pi/2, pi/2]
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			x_q[0] <= CORDIC_GAIN;
			y_q[0] <= '0;
			if (z_in > HALF_PI_Q30) begin
				z_q[0] <= PI_Q30 - z_in;
				n_q[0] <= 1'b1;
			end else if (z_in < -HALF_PI_Q30) begin
				z_q[0] <= -PI_Q30 - z_in;
				n_q[0] <= 1'b1;
			end else begin
				z_q[0] <= z_in;
				n_q[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < N_ITER; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (adv[i+1]) begin
				n_q[i+1] <= n_q[i];
				if (!z_q[i][33]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_q30(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_q30(i);
				end
			end
		end
	end

	assign x       = x_q[N_ITER];
	assign y       = y_q[N_ITER];
	assign neg_cos = n_q[N_ITER];

endmodule

// ===== rtl/erm_merge.sv =====
module erm_merge
	import erm_pkg::*;
(
	input  logic                    clk,
	input  logic [MERGE_STAGES-1:0] adv,
	input  cq_t                     x_x, y_x, x_y, y_y, x_z, y_z,
	input  logic                    nc_x, nc_y, nc_z,
	output ent_t                    m [0:8]
);

	tv_t sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	pr_t cycz_s2, cysz_s2, sxcy_s2, cxcy_s2, cxsz_s2, cxcz_s2, sxsz_s2, sxcz_s2;
	pr_t sxsy_s2, cxsy_s2;
	tv_t sy_s2, cz_s2, sz_s2;
	pr_t cycz_s3, cysz_s3, sxcy_s3, cxcy_s3, cxsz_s3, cxcz_s3, sxsz_s3, sxcz_s3;
	tv_t sy_s3;
	pp_t ah_cz_s3, ah_sz_s3, bh_cz_s3, bh_sz_s3;
	pp_t al_cz_s3, al_sz_s3, bl_cz_s3, bl_sz_s3;
	ent_t m_s4 [0:8];

	function automatic tv_t rnd20(input cq_t v, input logic neg);
		cq_t t;
		t = (neg ? -v : v) + 34'sd512;
		t = t >>> 10;
		return t[23:0];
	endfunction

	function automatic pp_t hi_mul(input pr_t a, input tv_t b);
		logic signed [27:0] h;
		h = a[47:20];
		return pp_t'(h * b);
	endfunction

	function automatic pp_t lo_mul(input pr_t a, input tv_t b);
		logic signed [20:0] l;
		l = {1'b0, a[19:0]};
		return pp_t'(l * b);
	endfunction

	// three-factor term plus or minus a two-factor term, in Q60
	function automatic logic signed [65:0] q3(input pp_t h, input pp_t l,
	                                          input pr_t p, input logic sub);
		logic signed [65:0] hs;
		hs = sub ? (66'(h) - 66'(p)) : (66'(h) + 66'(p));
		return (hs <<< 20) + 66'(l);
	endfunction

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			sx_s1 <= rnd20(y_x, 1'b0);
			cx_s1 <= rnd20(x_x, nc_x);
			sy_s1 <= rnd20(y_y, 1'b0);
			cy_s1 <= rnd20(x_y, nc_y);
			sz_s1 <= rnd20(y_z, 1'b0);
			cz_s1 <= rnd20(x_z, nc_z);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			cycz_s2 <= cy_s1 * cz_s1;
			cysz_s2 <= cy_s1 * sz_s1;
			sxcy_s2 <= sx_s1 * cy_s1;
			cxcy_s2 <= cx_s1 * cy_s1;
			cxsz_s2 <= cx_s1 * sz_s1;
			cxcz_s2 <= cx_s1 * cz_s1;
			sxsz_s2 <= sx_s1 * sz_s1;
			sxcz_s2 <= sx_s1 * cz_s1;
			sxsy_s2 <= sx_s1 * sy_s1;
			cxsy_s2 <= cx_s1 * sy_s1;
			sy_s2   <= sy_s1;
			cz_s2   <= cz_s1;
			sz_s2   <= sz_s1;
		end
	end

	// split the Q40 products at bit 20 to keep multipliers narrow
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			cycz_s3  <= cycz_s2;
			cysz_s3  <= cysz_s2;
			sxcy_s3  <= sxcy_s2;
			cxcy_s3  <= cxcy_s2;
			cxsz_s3  <= cxsz_s2;
			cxcz_s3  <= cxcz_s2;
			sxsz_s3  <= sxsz_s2;
			sxcz_s3  <= sxcz_s2;
			sy_s3    <= sy_s2;
			ah_cz_s3 <= hi_mul(sxsy_s2, cz_s2);
			al_cz_s3 <= lo_mul(sxsy_s2, cz_s2);
			ah_sz_s3 <= hi_mul(sxsy_s2, sz_s2);
			al_sz_s3 <= lo_mul(sxsy_s2, sz_s2);
			bh_cz_s3 <= hi_mul(cxsy_s2, cz_s2);
			bl_cz_s3 <= lo_mul(cxsy_s2, cz_s2);
			bh_sz_s3 <= hi_mul(cxsy_s2, sz_s2);
			bl_sz_s3 <= lo_mul(cxsy_s2, sz_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			m_s4[0] <= round_clamp(66'(cycz_s3) <<< 20);
			m_s4[1] <= round_clamp(66'(cysz_s3) <<< 20);
			m_s4[2] <= round_clamp(-(66'(sy_s3) <<< 40));
			m_s4[3] <= round_clamp(q3(ah_cz_s3, al_cz_s3, cxsz_s3, 1'b1));
			m_s4[4] <= round_clamp(q3(ah_sz_s3, al_sz_s3, cxcz_s3, 1'b0));
			m_s4[5] <= round_clamp(66'(sxcy_s3) <<< 20);
			m_s4[6] <= round_clamp(q3(bh_cz_s3, bl_cz_s3, sxsz_s3, 1'b0));
			m_s4[7] <= round_clamp(q3(bh_sz_s3, bl_sz_s3, sxcz_s3, 1'b1));
			m_s4[8] <= round_clamp(66'(cxcy_s3) <<< 20);
		end
	end

	assign m = m_s4;

endmodule

// ===== rtl/euler_to_rotation_matrix_unit.sv =====
// Euler angles (XYZ) to 3x3 rotation matrix.
// Channels: "angles" (sink) takes a request of three signed Q2.13 angles;
// "matrix" (source) returns nine signed Q1.14 entries in row-major order.
// Both use valid/ready; a request moves on a clock edge with both high.
// Three CORDIC lanes, one per angle, run side by side: one fold stage and
// one stage per CORDIC iteration. A four-stage merge then rounds sine and
// cosine, forms the products and sums, rounds and clamps each entry.
// Throughput: one request per cycle while matrix.ready is high, with no gap between requests.
// Stall: each stage holds while the next one is full and cannot move, so
// bubbles fill in; angles.ready drops only when every stage is full and
// matrix.ready is low. Nothing is lost or repeated.
// Reset (arst_n low): all valid bits clear at once; the datapath has no
// reset and no stored state between requests.
module euler_to_rotation_matrix_unit
	import erm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	erm_in_if.sink    angles,
	erm_out_if.source matrix
);

	logic [PIPE_DEPTH-1:0] vld_q;
	logic [PIPE_DEPTH-1:0] adv;
	cq_t  lx [0:2];
	cq_t  ly [0:2];
	logic lneg [0:2];
	ent_t m [0:8];

	// a stage loads when it is empty or its contents move on
	always_comb begin
		adv[PIPE_DEPTH-1] = !vld_q[PIPE_DEPTH-1] || matrix.ready;
		for (int k = PIPE_DEPTH - 2; k >= 0; k--)
			adv[k] = !vld_q[k] || adv[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < PIPE_DEPTH; k++) begin
				if (adv[k])
					vld_q[k] <= (k == 0) ? angles.valid : vld_q[k-1];
			end
		end
	end

	assign angles.ready = adv[0];

	// one lane per angle
	erm_cordic u_lane_x (
		.clk(clk), .adv(adv[LANE_STAGES-1:0]), .angle(angles.angle_x),
		.x(lx[0]), .y(ly[0]), .neg_cos(lneg[0])
	);
	erm_cordic u_lane_y (
		.clk(clk), .adv(adv[LANE_STAGES-1:0]), .angle(angles.angle_y),
		.x(lx[1]), .y(ly[1]), .neg_cos(lneg[1])
	);
	erm_cordic u_lane_z (
		.clk(clk), .adv(adv[LANE_STAGES-1:0]), .angle(angles.angle_z),
		.x(lx[2]), .y(ly[2]), .neg_cos(lneg[2])
	);

	// products, sums and rounding; last stage is the output register
	erm_merge u_merge (
		.clk(clk), .adv(adv[PIPE_DEPTH-1:LANE_STAGES]),
		.x_x(lx[0]), .y_x(ly[0]), .x_y(lx[1]), .y_y(ly[1]),
		.x_z(lx[2]), .y_z(ly[2]),
		.nc_x(lneg[0]), .nc_y(lneg[1]), .nc_z(lneg[2]),
		.m(m)
	);

	assign matrix.valid = vld_q[PIPE_DEPTH-1];
	assign matrix.m00   = m[0];
	assign matrix.m01   = m[1];
	assign matrix.m02   = m[2];
	assign matrix.m10   = m[3];
	assign matrix.m11   = m[4];
	assign matrix.m12   = m[5];
	assign matrix.m20   = m[6];
	assign matrix.m21   = m[7];
	assign matrix.m22   = m[8];

endmodule

// ===== test/tb_euler_to_rotation_matrix_unit.sv =====
`timescale 1ns / 100ps

module tb_euler_to_rotation_matrix_unit;
	import erm_pkg::*;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	} matrix_t;

	localparam int RANDOM_REQS = 1700;
	localparam int QUIET_TAIL  = 300;   // last requests run with no idling
	localparam int STALL_LIMIT = 2000;  // cycles without any accept
	localparam int DRAIN_WAIT  = 40;    // covers the pipeline latency

	// atan(2^-i) in Q30, truncated
	localparam logic signed [63:0] ATAN_TAB [24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

	logic clk;
	logic arst_n;

	erm_in_if  angles ();
	erm_out_if matrix ();

	euler_to_rotation_matrix_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.angles (angles.sink),
		.matrix (matrix.source)
	);

	angles_t pending_reqs[$];
	matrix_t expected_mats[$];
	int      mismatches = 0;
	int      idle_cycles = 0;
	bit      stim_done = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// sine and cosine in Q20 of a Q2.13 angle, via folded CORDIC
	function automatic void sin_cos(input logic signed [15:0] ang,
			output logic signed [63:0] s, output logic signed [63:0] c);
		logic signed [63:0] x, y, z, dx, dy;
		bit flip;
		int n;
		z = 64'(ang) * 131072;
		x = 64'sd652032874;
		y = 0;
		flip = 0;
		n = (TRIG_ITERATIONS > 24) ? 24 : TRIG_ITERATIONS;
		if (z > 64'sd1686629713) begin
			z = 64'sd3373259426 - z;
			flip = 1;
		end else if (z < -64'sd1686629713) begin
			z = -64'sd3373259426 - z;
			flip = 1;
		end
		for (int i = 0; i < n; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_TAB[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_TAB[i];
			end
		end
		if (flip)
			x = -x;
		c = (x + 512) >>> 10;
		s = (y + 512) >>> 10;
	endfunction

	// Q60 sum to clamped Q1.14
	function automatic logic signed [15:0] to_entry(input logic signed [63:0] q60);
		logic signed [63:0] v;
		v = (q60 + (64'sd1 <<< 45)) >>> 46;
		if (v > 16384)
			v = 16384;
		if (v < -16384)
			v = -16384;
		return v[15:0];
	endfunction

	function automatic matrix_t rotation_of(input angles_t a);
		logic signed [63:0] sx, cx, sy, cy, sz, cz, sxsy, cxsy, one;
		matrix_t m;
		one = 64'sd1048576;
		sin_cos(a.ax, sx, cx);
		sin_cos(a.ay, sy, cy);
		sin_cos(a.az, sz, cz);
		sxsy = sx * sy;
		cxsy = cx * sy;
		m.m00 = to_entry(cy * cz * one);
		m.m01 = to_entry(cy * sz * one);
		m.m02 = to_entry(-sy * one * one);
		m.m10 = to_entry(sxsy * cz - cx * sz * one);
		m.m11 = to_entry(sxsy * sz + cx * cz * one);
		m.m12 = to_entry(sx * cy * one);
		m.m20 = to_entry(cxsy * cz + sx * sz * one);
		m.m21 = to_entry(cxsy * sz - sx * cz * one);
		m.m22 = to_entry(cx * cy * one);
		return m;
	endfunction

	task automatic report(input string what, input logic signed [15:0] got,
			input logic signed [15:0] want);
		$display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// pick an angle: mostly in range, with folding corners and wild patterns
	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'(12868 + $urandom_range(0, 4) - 2);   // around pi/2
			2: return 16'(-12868 + $urandom_range(0, 4) - 2);
			3: return 16'(25736 - $urandom_range(0, 3));
			default: return 16'($signed($urandom_range(0, 51472)) - 25736);
		endcase
	endfunction

	// stimulus
	initial begin
		angles_t a;
		logic signed [15:0] corners[] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
			-16'sd12868, 16'sd12869, -16'sd12869, 16'sh7FFF, -16'sh8000, 16'sd1, -16'sd1,
			16'sd32767, 16'sd6434};
		foreach (corners[i]) begin
			a.ax = corners[i];
			a.ay = corners[(i + 3) % corners.size()];
			a.az = corners[(i + 7) % corners.size()];
			pending_reqs.push_back(a);
		end
		// gimbal lock: y at plus and minus pi/2
		pending_reqs.push_back('{16'sd1000, 16'sd12868, 16'sd2000});
		pending_reqs.push_back('{-16'sd3000, -16'sd12868, 16'sd500});
		pending_reqs.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
		pending_reqs.push_back('{-16'sh8000, -16'sh8000, -16'sh8000});
		for (int i = 0; i < RANDOM_REQS; i++) begin
			a.ax = rand_angle();
			a.ay = rand_angle();
			a.az = rand_angle();
			pending_reqs.push_back(a);
		end
	end

	// reset, then end of run
	initial begin
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		wait (stim_done && expected_mats.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// driver: random idle bursts, none near the end
	int src_gap = 0;
	initial begin
		angles.valid = 0;
		angles.angle_x = 0;
		angles.angle_y = 0;
		angles.angle_z = 0;
		matrix.ready = 0;
	end

	always @(posedge clk) begin
		automatic bit quiet;
		if (arst_n) begin
			quiet = pending_reqs.size() < QUIET_TAIL;
			if (angles.valid && angles.ready) begin
				expected_mats.push_back(rotation_of({angles.angle_x, angles.angle_y,
					angles.angle_z}));
			end
			if (!angles.valid || angles.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					angles.valid <= 0;
				end else if (pending_reqs.size() > 0) begin
					automatic angles_t r = pending_reqs.pop_front();
					angles.valid   <= 1;
					angles.angle_x <= r.ax;
					angles.angle_y <= r.ay;
					angles.angle_z <= r.az;
					if (!quiet && $urandom_range(0, 7) == 0)
						src_gap = $urandom_range(1, 9);
				end else begin
					angles.valid <= 0;
					if (angles.valid && angles.ready)
						stim_done = 1;
				end
			end
		end
	end

	// monitor and sink stalls
	int snk_gap = 0;
	always @(posedge clk) begin
		automatic matrix_t want;
		if (arst_n) begin
			if (matrix.valid && matrix.ready) begin
				if (expected_mats.size() == 0) begin
					$display("MISMATCH: matrix with no request outstanding at %0t", $realtime);
					mismatches++;
				end else begin
					want = expected_mats.pop_front();
					if (matrix.m00 !== want.m00) report("m00", matrix.m00, want.m00);
					if (matrix.m01 !== want.m01) report("m01", matrix.m01, want.m01);
					if (matrix.m02 !== want.m02) report("m02", matrix.m02, want.m02);
					if (matrix.m10 !== want.m10) report("m10", matrix.m10, want.m10);
					if (matrix.m11 !== want.m11) report("m11", matrix.m11, want.m11);
					if (matrix.m12 !== want.m12) report("m12", matrix.m12, want.m12);
					if (matrix.m20 !== want.m20) report("m20", matrix.m20, want.m20);
					if (matrix.m21 !== want.m21) report("m21", matrix.m21, want.m21);
					if (matrix.m22 !== want.m22) report("m22", matrix.m22, want.m22);
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				matrix.ready <= 0;
			end else begin
				matrix.ready <= 1;
				if (pending_reqs.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0)
					snk_gap = $urandom_range(1, 9);
			end
		end
	end

	// watchdog: cycles with no accept on either side
	always @(posedge clk) begin
		if ((angles.valid && angles.ready) || (matrix.valid && matrix.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
